// ===== design/pic_pkg.sv =====
// Package for the PI drive controller: widths, constants, codes and shared types.
// Used by the channel interfaces and by every module of the design. It depends on nothing.
package pic_pkg;

    localparam int FULL_SCALE = 10000;
    localparam int FRAC_BITS  = 16;
    localparam int DUTY_W     = 14;
    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 32;
    localparam int INTEG_W    = 31;
    localparam int ERR_W      = DATA_W + 1;
    localparam int PROD_W     = GAIN_W + ERR_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int CFG_IDX_W  = 1;

    // Full scale in Q16.16, at the width of the wide sums.
    localparam logic signed [SUM_W-1:0] FULL_Q_WIDE = SUM_W'(FULL_SCALE) << FRAC_BITS;
    // Full scale as a signed value one bit wider than the request field.
    localparam logic signed [DATA_W:0] FULL_SCALE_S = (DATA_W + 1)'(FULL_SCALE);

    typedef enum logic [1:0] {
        ACT_MANUAL = 2'd0,
        ACT_AUTO   = 2'd1,
        ACT_TICK   = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 1'b0,
        CFG_INTEG_GAIN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop;
        logic signed [GAIN_W-1:0] integ;
    } t_gains;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] measurement;
    } t_item;

    // Saturate a signed Q16.16 sum to the range 0..full scale.
    function automatic logic [INTEG_W-1:0] clamp_q(input logic signed [SUM_W-1:0] x);
        logic [INTEG_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > FULL_Q_WIDE) begin
            res = FULL_Q_WIDE[INTEG_W-1:0];
        end else begin
            res = x[INTEG_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/pic_in_if.sv =====
// Input channel of the PI drive controller: valid/ready plus one command item.
// Depends on pic_pkg for the field widths.
interface pic_in_if
    import pic_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] measurement;

    modport source (output valid, action, value, measurement, input ready);
    modport sink   (input valid, action, value, measurement, output ready);
endinterface

// ===== design/pic_out_if.sv =====
// Result channel of the PI drive controller: valid/ready plus duty and mode.
// Depends on pic_pkg for the field widths.
interface pic_out_if
    import pic_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic              auto_mode;

    modport source (output valid, duty, auto_mode, input ready);
    modport sink   (input valid, duty, auto_mode, output ready);
endinterface

// ===== design/pic_cfg_regs.sv =====
// Gain registers of the PI drive controller, written through the plain write port.
// Depends on pic_pkg.
module pic_cfg_regs
    import pic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output t_gains               o_gains
);
    t_gains r_gains;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:  r_gains.prop  <= $signed(i_cfg_data);
                CFG_INTEG_GAIN: r_gains.integ <= $signed(i_cfg_data);
                default:        r_gains <= r_gains;
            endcase
        end
    end

    assign o_gains = r_gains;
endmodule

// ===== design/pic_in_stage.sv =====
// Input register of the PI drive controller: holds one accepted item for the core.
// Depends on pic_pkg and pic_in_if.
module pic_in_stage
    import pic_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    pic_in_if.sink i_item,
    output t_item o_item,
    output logic  o_valid,
    input  logic  i_ready
);
    logic  r_valid;
    t_item r_item;
    logic  w_take;

    // A new item may enter when the stage is empty or its item moves on now.
    assign i_item.ready = !r_valid || i_ready;
    assign w_take       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.action      <= i_item.action;
            r_item.value       <= i_item.value;
            r_item.measurement <= i_item.measurement;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;
endmodule

// ===== design/pic_core.sv =====
// Control core of the PI drive controller: mode, target, integral and duty state,
// the one-pass PI update and the result register. Depends on pic_pkg and pic_out_if.
module pic_core
    import pic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_item     i_item,
    input  t_gains    i_gains,
    pic_out_if.source o_result
);
    logic                     r_auto;
    logic signed [DATA_W-1:0] r_setpoint;
    logic [INTEG_W-1:0]       r_integ;
    logic [DUTY_W-1:0]        r_duty;
    logic                     r_out_valid;

    logic                     n_auto;
    logic signed [DATA_W-1:0] n_setpoint;
    logic [INTEG_W-1:0]       n_integ;
    logic [DUTY_W-1:0]        n_duty;

    logic                     w_move;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [PROD_W-1:0] w_integ_prod;
    logic signed [PROD_W-1:0] w_prop_prod;
    logic signed [SUM_W-1:0]  w_integ_sum;
    logic [INTEG_W-1:0]       w_integ_clamped;
    logic signed [SUM_W-1:0]  w_out_sum;
    logic [INTEG_W-1:0]       w_out_clamped;
    logic signed [DATA_W:0]   w_req;

    // The result slot is free when empty or when its result is taken now.
    assign o_ready = !r_out_valid || o_result.ready;
    assign w_move  = i_valid && o_ready;

    // Error is exact in 17 bits; both gain products are exact Q16.16 values.
    assign w_err        = {r_setpoint[DATA_W-1], r_setpoint}
                          - {i_item.measurement[DATA_W-1], i_item.measurement};
    assign w_integ_prod = i_gains.integ * w_err;
    assign w_prop_prod  = i_gains.prop * w_err;

    assign w_integ_sum     = $signed({{(SUM_W - INTEG_W){1'b0}}, r_integ})
                             + {w_integ_prod[PROD_W-1], w_integ_prod};
    assign w_integ_clamped = clamp_q(w_integ_sum);
    assign w_out_sum       = $signed({{(SUM_W - INTEG_W){1'b0}}, w_integ_clamped})
                             + {w_prop_prod[PROD_W-1], w_prop_prod};
    assign w_out_clamped   = clamp_q(w_out_sum);

    assign w_req = {i_item.value[DATA_W-1], i_item.value};

    always_comb begin
        n_auto     = r_auto;
        n_setpoint = r_setpoint;
        n_integ    = r_integ;
        n_duty     = r_duty;
        unique case (t_action'(i_item.action))
            ACT_MANUAL: begin
                n_auto = 1'b0;
                if (w_req <= 0) begin
                    n_duty = '0;
                end else if (w_req >= FULL_SCALE_S) begin
                    n_duty = DUTY_W'(FULL_SCALE);
                end else begin
                    n_duty = w_req[DUTY_W-1:0];
                end
            end
            ACT_AUTO: begin
                // Coming from manual, start the integral at the present duty
                // so that the drive does not jump.
                if (!r_auto) begin
                    n_integ = {{(INTEG_W - DUTY_W - FRAC_BITS){1'b0}}, r_duty,
                               {FRAC_BITS{1'b0}}};
                end
                n_auto     = 1'b1;
                n_setpoint = i_item.value;
            end
            ACT_TICK: begin
                if (r_auto) begin
                    n_integ = w_integ_clamped;
                    n_duty  = w_out_clamped[FRAC_BITS +: DUTY_W];
                end
            end
            default: begin
                n_auto = r_auto;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto      <= 1'b0;
            r_setpoint  <= '0;
            r_integ     <= '0;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_move) begin
                r_auto      <= n_auto;
                r_setpoint  <= n_setpoint;
                r_integ     <= n_integ;
                r_duty      <= n_duty;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The state only changes when an item moves into the result slot, so the
    // state registers double as the result payload.
    assign o_result.valid     = r_out_valid;
    assign o_result.duty      = r_duty;
    assign o_result.auto_mode = r_auto;
endmodule

// ===== design/pi_controller_manual_auto.sv =====
// Top level of the PI drive controller with manual and automatic modes.
// Depends on pic_pkg, pic_in_if, pic_out_if, pic_cfg_regs, pic_in_stage and pic_core.
//
// Commands arrive on i_item, one per transfer: a manual duty set, an auto target
// set, or a control tick carrying one measurement. Every command produces exactly
// one transfer on o_result with the duty after the command and the mode flag.
// The gains (signed Q16.16) are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while the block is idle, and the block itself has
// no check for this. Index 0 is the proportional gain, index 1 the integral gain.
//
// Throughput is one command per cycle while the receiver takes results. A command
// is held in the input register and is then processed in a single pass: the two
// gain multiplies, the integral update with clamping and the output clamp all
// happen between the input register and the state/result registers, which load
// when the command leaves the input register.
//
// When the receiver stalls, the result register holds its value and the input
// register still takes one further command; after that i_item.ready drops until
// the result is taken. Synchronous reset clears the gains, selects manual mode,
// and zeroes the target, integral and duty.
module pi_controller_manual_auto
    import pic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pic_in_if.sink               i_item,
    pic_out_if.source            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data
);
    t_gains w_gains;
    t_item  w_item;
    logic   w_stage_valid;
    logic   w_stage_ready;
    logic   w_move;

    pic_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_gains    (w_gains)
    );

    pic_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_item  (w_item),
        .o_valid (w_stage_valid),
        .i_ready (w_stage_ready)
    );

    pic_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_stage_valid),
        .o_ready  (w_stage_ready),
        .i_item   (w_item),
        .i_gains  (w_gains),
        .o_result (o_result)
    );

    // A command is processed at the edge where it leaves the input register.
    assign w_move = w_stage_valid && w_stage_ready;

    // The reported duty never leaves the range 0..full scale.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.duty <= DUTY_W'(FULL_SCALE))
        else $error("duty above full scale");

    // A manual command always leaves automatic mode.
    a_manual_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && (w_item.action == ACT_MANUAL) |=> !o_result.auto_mode)
        else $error("manual command did not leave automatic mode");

    // An auto command enters automatic mode without moving the duty.
    a_bumpless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && (w_item.action == ACT_AUTO) |=> o_result.auto_mode && $stable(o_result.duty))
        else $error("auto command changed the duty or the mode stayed manual");

    // A tick in manual mode changes nothing.
    a_manual_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && (w_item.action == ACT_TICK) && !o_result.auto_mode
        |=> !o_result.auto_mode && $stable(o_result.duty))
        else $error("tick in manual mode changed the state");
endmodule
